// File: rtl/core/tsg_pkg.sv
package tsg_pkg;

  localparam int NUM_SLOTS        = 32;
  localparam int MEMBERS_PER_SLOT = 64;

  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W      = $clog2(MEMBERS_PER_SLOT + 1);
  localparam int RULE_DEPTH = NUM_SLOTS * MEMBERS_PER_SLOT;
  localparam int RULE_AW    = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;

  localparam int ADDR_W       = 32;
  localparam int PORT_W       = 16;
  localparam int PROTO_W      = 8;
  localparam int PREFIX_W     = 6;
  localparam int CLASS_W      = 7;
  localparam int OUT_SLOT_W   = 5;
  localparam int OUT_POS_W    = 6;
  localparam int TOTAL_W      = 12;
  localparam int ADDR_PAIR_W  = 2 * ADDR_W;
  localparam int PORTS_ACT_W  = 2 * PORT_W + PROTO_W + 1;

  // x / 1000 == (x * ceil(2^26 / 1000)) >> 26 for every 16-bit x
  localparam int CLASS_RECIP  = 67109;
  localparam int CLASS_SHIFT  = 26;
  localparam int CLASS_PROD_W = PORT_W + 17;

  typedef enum logic [1:0] {
    ST_STORED     = 2'd0,
    ST_TABLE_FULL = 2'd1,
    ST_LIST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [PREFIX_W-1:0] src_prefix;
    logic [PREFIX_W-1:0] dst_prefix;
    logic [CLASS_W-1:0]  src_class;
    logic [CLASS_W-1:0]  dst_class;
    logic [PROTO_W-1:0]  protocol;
  } key_t;

  typedef struct packed {
    logic commit;
    logic any_hit;
  } cell_cmd_t;

  typedef struct packed {
    logic             hit;
    logic             take;
    logic             used;
    logic [CNT_W-1:0] count;
  } cell_stat_t;

  function automatic logic [PREFIX_W-1:0] prefix_of(input logic [ADDR_W-1:0] addr);
    logic [PREFIX_W-1:0] len;
    len = PREFIX_W'(ADDR_W);
    for (int b = 0; b < 4; b++) begin
      if (addr[8*b +: 8] == 8'd0) len = len - PREFIX_W'(8);
    end
    return len;
  endfunction

  function automatic logic [CLASS_W-1:0] port_class(input logic [PORT_W-1:0] port);
    logic [CLASS_PROD_W-1:0] prod;
    prod = CLASS_PROD_W'(port) * CLASS_PROD_W'(CLASS_RECIP);
    return CLASS_W'(prod >> CLASS_SHIFT);
  endfunction

endpackage

// File: rtl/core/tsg_ram.sv
module tsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/tsg_cell.sv
module tsg_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  tsg_pkg::key_t          probe,
  input  tsg_pkg::cell_cmd_t     cmd,
  input  logic                   prev_used,
  output tsg_pkg::cell_stat_t    stat
);
  import tsg_pkg::*;

  logic             used;
  key_t             key;
  logic [CNT_W-1:0] count;
  logic             hit;
  logic             head;
  logic             take;

  assign hit  = used && (key == probe);
  // first free cell of the chain: the one whose upstream neighbor is taken
  assign head = !used && prev_used;
  assign take = hit || (!cmd.any_hit && head);

  assign stat.hit   = hit;
  assign stat.take  = take;
  assign stat.used  = used;
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      count <= '0;
    end else if (cmd.commit && take) begin
      used  <= 1'b1;
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && take && !used) key <= probe;
  end

endmodule

// File: rtl/core/tuple_space_rule_grouper.sv
// Tuple-space rule grouper. Each request is one firewall rule; the block derives its tuple key
// (prefix length per address from its zero bytes, port classes of port / 1000, protocol),
// finds the slot holding that key in a chain of NUM_SLOTS slot cells or opens the next free
// one, appends the rule to that slot's list in the rule store and answers with one result.
// The key is derived from the request as it is taken (the port class multiply lies on that
// path) and registered in the key stage; there it is compared against all slot cells at once,
// and as the result enters the output register the slot update and the single rule store
// write are committed. A rule can be taken in every cycle while the output side keeps up.
// The slot cells and counters are cleared by reset; the rule store needs no clearing.
module tuple_space_rule_grouper (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tsg_pkg::ADDR_W-1:0]        src_addr,
  input  logic [tsg_pkg::ADDR_W-1:0]        dst_addr,
  input  logic [tsg_pkg::PORT_W-1:0]        src_port,
  input  logic [tsg_pkg::PORT_W-1:0]        dst_port,
  input  logic [tsg_pkg::PROTO_W-1:0]       protocol,
  input  logic                              action_deny,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tsg_pkg::OUT_SLOT_W-1:0]    slot_index,
  output logic                              new_slot,
  output logic [tsg_pkg::OUT_POS_W-1:0]     member_pos,
  output logic [tsg_pkg::PREFIX_W-1:0]      src_prefix,
  output logic [tsg_pkg::PREFIX_W-1:0]      dst_prefix,
  output logic [tsg_pkg::CLASS_W-1:0]       src_port_class,
  output logic [tsg_pkg::CLASS_W-1:0]       dst_port_class,
  output logic [1:0]                        status,
  output logic [tsg_pkg::TOTAL_W-1:0]       total_rules
);
  import tsg_pkg::*;

  // key stage
  logic                a_valid;
  key_t                a_key;
  logic [ADDR_W-1:0]   a_src_addr;
  logic [ADDR_W-1:0]   a_dst_addr;
  logic [PORT_W-1:0]   a_src_port;
  logic [PORT_W-1:0]   a_dst_port;
  logic                a_action;
  key_t                in_key;

  logic                advance;
  logic                accept;

  cell_cmd_t           cmd;
  cell_stat_t          stat [NUM_SLOTS];
  logic [NUM_SLOTS:0]  used_chain;

  logic                hit_any;
  logic                take_any;
  logic [SLOT_W-1:0]   sel_slot;
  logic [CNT_W-1:0]    sel_cnt;
  status_t             status_next;
  logic                store;
  logic [RULE_AW-1:0]  rule_addr;

  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  total_next;
  status_t             status_q;

  assign advance  = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || advance;
  assign accept   = in_valid && in_ready;

  assign in_key.src_prefix = prefix_of(src_addr);
  assign in_key.dst_prefix = prefix_of(dst_addr);
  assign in_key.src_class  = port_class(src_port);
  assign in_key.dst_class  = port_class(dst_port);
  assign in_key.protocol   = protocol;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_key      <= in_key;
      a_src_addr <= src_addr;
      a_dst_addr <= dst_addr;
      a_src_port <= src_port;
      a_dst_port <= dst_port;
      a_action   <= action_deny;
    end
  end

  // slot cell chain
  assign used_chain[0] = 1'b1;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    tsg_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe     (a_key),
      .cmd       (cmd),
      .prev_used (used_chain[g]),
      .stat      (stat[g])
    );
    assign used_chain[g+1] = stat[g].used;
  end

  // keys are unique across slots, so at most one cell takes the rule
  always_comb begin
    hit_any  = 1'b0;
    take_any = 1'b0;
    sel_slot = '0;
    sel_cnt  = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hit_any  = hit_any | stat[i].hit;
      take_any = take_any | stat[i].take;
      if (stat[i].take) begin
        sel_slot = sel_slot | SLOT_W'(i);
        sel_cnt  = sel_cnt | stat[i].count;
      end
    end
  end

  always_comb begin
    if (!take_any) begin
      status_next = ST_TABLE_FULL;
    end else if (sel_cnt >= CNT_W'(MEMBERS_PER_SLOT)) begin
      status_next = ST_LIST_FULL;
    end else begin
      status_next = ST_STORED;
    end
  end

  assign store       = (status_next == ST_STORED);
  assign cmd.commit  = advance && store;
  assign cmd.any_hit = hit_any;
  assign total_next  = total + TOTAL_W'(1);

  assign rule_addr = RULE_AW'(sel_slot) * RULE_AW'(MEMBERS_PER_SLOT) + RULE_AW'(sel_cnt);

  tsg_ram #(
    .WIDTH (ADDR_PAIR_W),
    .DEPTH (RULE_DEPTH)
  ) u_addr_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (rule_addr),
    .wdata ({a_src_addr, a_dst_addr}),
    .raddr (rule_addr),
    .rdata ()
  );

  tsg_ram #(
    .WIDTH (PORTS_ACT_W),
    .DEPTH (RULE_DEPTH)
  ) u_ports_store (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (rule_addr),
    .wdata ({a_src_port, a_dst_port, a_key.protocol, a_action}),
    .raddr (rule_addr),
    .rdata ()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.commit) begin
      total <= total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      slot_index     <= take_any ? OUT_SLOT_W'(sel_slot) : '0;
      new_slot       <= store && !hit_any;
      member_pos     <= store ? OUT_POS_W'(sel_cnt) : '0;
      src_prefix     <= a_key.src_prefix;
      dst_prefix     <= a_key.dst_prefix;
      src_port_class <= a_key.src_class;
      dst_port_class <= a_key.dst_class;
      status_q       <= status_next;
      total_rules    <= store ? total_next : total;
    end
  end

  assign status = status_q;

endmodule

// File: rtl/core/tsg_checker.sv
module tsg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [tsg_pkg::ADDR_W-1:0]        src_addr,
  input logic [tsg_pkg::ADDR_W-1:0]        dst_addr,
  input logic [tsg_pkg::PORT_W-1:0]        src_port,
  input logic [tsg_pkg::PORT_W-1:0]        dst_port,
  input logic [tsg_pkg::PROTO_W-1:0]       protocol,
  input logic                              action_deny,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tsg_pkg::OUT_SLOT_W-1:0]    slot_index,
  input logic                              new_slot,
  input logic [tsg_pkg::OUT_POS_W-1:0]     member_pos,
  input logic [tsg_pkg::PREFIX_W-1:0]      src_prefix,
  input logic [tsg_pkg::PREFIX_W-1:0]      dst_prefix,
  input logic [tsg_pkg::CLASS_W-1:0]       src_port_class,
  input logic [tsg_pkg::CLASS_W-1:0]       dst_port_class,
  input logic [1:0]                        status,
  input logic [tsg_pkg::TOTAL_W-1:0]       total_rules
);
  import tsg_pkg::*;

  // a stalled result holds its slot, count and status fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(member_pos)
      && $stable(total_rules) && $stable(status))
    else $error("stalled result changed");

  // a rejected rule never claims a list position or a new slot
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_STORED |-> !new_slot && member_pos == '0)
    else $error("rejected rule reports a position");

  a_full_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TABLE_FULL |-> slot_index == '0)
    else $error("table full with nonzero slot");

  // a freshly opened slot starts its list at position zero
  a_open_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_slot |-> member_pos == '0 && status == ST_STORED)
    else $error("new slot not at first position");

  a_prefix_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> src_prefix[2:0] == 3'd0 && dst_prefix[2:0] == 3'd0
      && src_prefix <= PREFIX_W'(ADDR_W) && dst_prefix <= PREFIX_W'(ADDR_W))
    else $error("prefix length not a whole number of bytes");

endmodule

bind tuple_space_rule_grouper tsg_checker u_tsg_checker (.*);
